// ----- src/rational_arith_unit_assert.svh -----
// Assertion macros shared by the checker
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RAU_ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- src/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam logic [2:0] CMD_NORM = 3'd5;
    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_OVF = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic chk;
        logic gstep;
        logic qstart;
        logic qstep;
    } rau_cmd_t;

    typedef struct packed {
        logic done_early;
        logic g_done;
        logic q_done;
    } rau_sts_t;
endpackage
`default_nettype wire

// ----- src/rau_dp.sv -----
`default_nettype none
module rau_dp #(
    parameter int WORD_BITS = 32
) (
    input  wire logic clk,
    input  wire rau_pkg::rau_cmd_t ctl,
    output rau_pkg::rau_sts_t sts,
    input  wire logic [2:0] cmd,
    input  wire logic [WORD_BITS-1:0] a_num,
    input  wire logic [WORD_BITS-1:0] a_den,
    input  wire logic [WORD_BITS-1:0] b_num,
    input  wire logic [WORD_BITS-2:0] b_den,
    output logic [WORD_BITS-1:0] r_num,
    output logic [WORD_BITS-2:0] r_den,
    output logic less,
    output logic equal,
    output logic [1:0] error
);
    import rau_pkg::*;
    localparam int W = WORD_BITS;
    localparam int P = 2 * W + 2;
    localparam int CW = $clog2(W + 1);
    localparam int IW = $clog2(W);

    logic [2:0] cmd_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg;
    logic signed [W:0] bd_reg;
    logic signed [P-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [P-1:0] p1_next, p2_next, p3_next;
    logic signed [P-1:0] n_s, d_s;
    logic [W-1:0] n_reg, d_reg, x_reg, y_reg, q_reg, rem_reg;
    logic [W-1:0] x_next, y_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg;
    logic sel_reg, neg_reg, early_reg;
    logic [W-1:0] rnum_reg;
    logic [W-2:0] rden_reg;
    logic less_reg, equal_reg;
    logic [1:0] err_reg;
    logic signed [P-1:0] wmax, wmin;
    logic [W:0] trial;
    logic [W-1:0] dvd;
    logic [IW-1:0] bit_idx;

    assign wmax = (P'(1) <<< (W - 1)) - P'(1);
    assign wmin = -wmax - P'(1);

    // cross products, one multiplier per product
    always_comb
    begin
        p1_next = P'(an_reg) * P'(bd_reg);
        p2_next = P'(bn_reg) * P'(ad_reg);
        p3_next = P'(ad_reg) * P'(bd_reg);
        if (cmd_reg == CMD_MUL)
        begin
            p1_next = P'(an_reg) * P'(bn_reg);
        end
        else if (cmd_reg == CMD_DIV)
        begin
            p3_next = P'(ad_reg) * P'(bn_reg);
        end
    end

    always_comb
    begin
        n_s = '0;
        d_s = p3_reg;
        unique case (cmd_reg)
            CMD_ADD:  n_s = p1_reg + p2_reg;
            CMD_SUB:  n_s = p1_reg - p2_reg;
            CMD_MUL, CMD_DIV: n_s = p1_reg;
            CMD_NORM:
            begin
                n_s = P'(an_reg);
                d_s = P'(ad_reg);
            end
            default: n_s = '0;
        endcase
    end

    // binary gcd step; every step drops at least one bit from x and y together
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        if (!x_reg[0] && !y_reg[0])
        begin
            x_next = x_reg >> 1;
            y_next = y_reg >> 1;
            k_next = k_reg + CW'(1);
        end
        else if (!x_reg[0])
        begin
            x_next = x_reg >> 1;
        end
        else if (!y_reg[0])
        begin
            y_next = y_reg >> 1;
        end
        else if (x_reg > y_reg)
        begin
            x_next = y_reg;
            y_next = (x_reg - y_reg) >> 1;
        end
        else
        begin
            y_next = (y_reg - x_reg) >> 1;
        end
    end

    assign dvd = sel_reg ? d_reg : n_reg;
    assign bit_idx = IW'(CW'(W - 1) - cnt_reg);
    assign trial = {rem_reg, dvd[bit_idx]} - {1'b0, x_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= {2'b00, b_den};
        end
        if (ctl.mul)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
        if (ctl.chk)
        begin
            early_reg <= 1'b1;
            rnum_reg <= '0;
            rden_reg <= '0;
            less_reg <= 1'b0;
            equal_reg <= 1'b0;
            err_reg <= ERR_OK;
            if (cmd_reg == CMD_CMP)
            begin
                less_reg <= p1_reg < p2_reg;
                equal_reg <= (an_reg == bn_reg) && (ad_reg == W'(bd_reg));
            end
            else if (cmd_reg == CMD_DIV && bn_reg == '0)
            begin
                err_reg <= ERR_DIV0;
            end
            else if (cmd_reg > CMD_NORM)
            begin
                err_reg <= ERR_OK;
            end
            else if (n_s > wmax || n_s < wmin || d_s > wmax || d_s < wmin)
            begin
                err_reg <= ERR_OVF;
            end
            else if (d_s == '0)
            begin
                err_reg <= ERR_DIV0;
            end
            else if (n_s == '0)
            begin
                rden_reg <= (W-1)'(1);
            end
            else if (d_s < 0 && (n_s == wmin || d_s == wmin))
            begin
                err_reg <= ERR_OVF;
            end
            else
            begin
                early_reg <= 1'b0;
                neg_reg <= (n_s < 0) != (d_s < 0);
                n_reg <= (n_s < 0) ? W'(-n_s) : W'(n_s);
                d_reg <= (d_s < 0) ? W'(-d_s) : W'(d_s);
                x_reg <= (n_s < 0) ? W'(-n_s) : W'(n_s);
                y_reg <= (d_s < 0) ? W'(-d_s) : W'(d_s);
                k_reg <= '0;
            end
        end
        // x << k holds the gcd when y reaches zero
        if (ctl.gstep)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            k_reg <= k_next;
        end
        if (ctl.qstart)
        begin
            x_reg <= x_reg << k_reg;
            cnt_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
        end
        // restoring divide, one bit a beat; numerator then denominator
        if (ctl.qstep)
        begin
            if (trial[W])
            begin
                rem_reg <= {rem_reg[W-2:0], dvd[bit_idx]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                cnt_reg <= '0;
                rem_reg <= '0;
                if (!sel_reg)
                begin
                    rnum_reg <= neg_reg ? -{q_reg[W-2:0], ~trial[W]}
                                        : {q_reg[W-2:0], ~trial[W]};
                end
                else
                begin
                    rden_reg <= {q_reg[W-3:0], ~trial[W]};
                end
                sel_reg <= ~sel_reg;
            end
        end
        if (ctl.load)
        begin
            sel_reg <= 1'b0;
        end
    end

    assign sts.done_early = early_reg;
    assign sts.g_done = (y_reg == '0);
    assign sts.q_done = (cnt_reg == CW'(W - 1)) && sel_reg;
    assign r_num = rnum_reg;
    assign r_den = rden_reg;
    assign less = less_reg;
    assign equal = equal_reg;
    assign error = err_reg;
endmodule
`default_nettype wire

// ----- src/rau_ctrl.sv -----
`default_nettype none
module rau_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  wire logic m_tready,
    output rau_pkg::rau_cmd_t ctl,
    input  wire rau_pkg::rau_sts_t sts
);
    import rau_pkg::*;
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_DEC  = 7'b0001000,
        S_GCD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
                if (s_tvalid) state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                ctl.chk = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = sts.done_early ? S_OUT : S_GCD;
            end
            S_GCD:
            begin
                if (sts.g_done)
                begin
                    ctl.qstart = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    ctl.gstep = 1'b1;
                end
            end
            S_DIV:
            begin
                ctl.qstep = 1'b1;
                if (sts.q_done) state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ----- src/rational_arith_unit.sv -----
// Rational arithmetic unit: one result beat for each operand beat.
// Slave channel: tdata = {b_den, b_num, a_den, a_num, cmd} packed from bit 0.
// Master channel: tdata = {error, equal, less, r_den, r_num} packed from bit 0.
// One beat is processed at a time; s_tready is high only while idle.
// Compare, errors, zero results and unused codes skip the gcd loop and divides.
// Arithmetic results add a binary gcd loop (one step per cycle) and two
// bit-serial divides by the gcd, numerator then denominator.
// The gcd loop sets the spread in latency. The next beat can be taken in
// the cycle after the result beat is accepted.
// The result is held in registers with m_tvalid high until m_tready; a
// stalled receiver holds the unit and no new beat is taken.
// Reset (rst_n low, asynchronous) returns to idle and drops any beat
// in flight.
`default_nettype none
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    // cmd, a_num, a_den, b_num, b_den
    input  wire logic [((3 + 4 * WORD_BITS - 1 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // r_num, r_den, less, equal, error
    output logic [((2 * WORD_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata
);
    import rau_pkg::*;
    localparam int W = WORD_BITS;
    localparam int MB = ((2 * W + 3 + 7) / 8) * 8;
    rau_cmd_t ctl;
    rau_sts_t sts;
    logic [W-1:0] r_num;
    logic [W-2:0] r_den;
    logic less, equal;
    logic [1:0] error;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .ctl(ctl), .sts(sts)
    );

    rau_dp #(.WORD_BITS(W)) u_dp (
        .clk(clk), .ctl(ctl), .sts(sts),
        .cmd(s_tdata[2:0]),
        .a_num(s_tdata[3 +: W]),
        .a_den(s_tdata[3 + W +: W]),
        .b_num(s_tdata[3 + 2 * W +: W]),
        .b_den(s_tdata[3 + 3 * W +: W - 1]),
        .r_num(r_num), .r_den(r_den), .less(less), .equal(equal), .error(error)
    );

    assign m_tdata = MB'({error, equal, less, r_den, r_num});
endmodule
`default_nettype wire

// ----- src/rau_checker.sv -----
`default_nettype none
`include "rational_arith_unit_assert.svh"
module rau_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready
);
    `RAU_ASSERT_IMPL(a_excl, clk, rst_n, 1'b1, !(s_tready && m_tvalid))
    `RAU_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `RAU_ASSERT_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready && !m_tvalid)
    `RAU_ASSERT_NEXT(a_back, clk, rst_n, m_tvalid && m_tready, s_tready)
endmodule
bind rational_arith_unit rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready)
);
`default_nettype wire

// ----- tb/rational_arith_unit_tb.sv -----
`timescale 1ns / 100ps
module rational_arith_unit_tb;
    import rau_pkg::*;

    localparam int W = 32;
    localparam int S_BITS = ((3 + 4 * W - 1 + 7) / 8) * 8;
    localparam int M_BITS = ((2 * W + 3 + 7) / 8) * 8;
    localparam int N_RANDOM = 1530;
    localparam logic [2:0] CMD_NOP6 = 3'd6;
    localparam logic [2:0] CMD_NOP7 = 3'd7;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } operands_t;

    // last field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [1:0]         error;
        logic               equal;
        logic               less;
        logic [30:0]        r_den;
        logic signed [31:0] r_num;
    } quotient_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_BITS-1:0] m_tdata;

    operands_t pending_ops[$];
    quotient_t expected_q[$];
    operands_t in_flight;
    int gap_left;
    int accepted;
    int results_seen;
    int fail_count;
    int hold_left;
    int total_items;
    bit hold_done;
    bit stim_done;

    rational_arith_unit #(.WORD_BITS(W)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    function automatic longint gcd64(longint x, longint y);
        longint t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic quotient_t reduce_frac(longint n, longint d);
        quotient_t q;
        longint g;
        q = '0;
        if (n > WMAX || n < WMIN || d > WMAX || d < WMIN)
            q.error = ERR_OVF;
        else if (d == 0)
            q.error = ERR_DIV0;
        else if (n == 0)
        begin
            q.r_den = 31'd1;
        end
        else
        begin
            if (d < 0)
            begin
                if (n == WMIN || d == WMIN)
                begin
                    q.error = ERR_OVF;
                    return q;
                end
                n = -n;
                d = -d;
            end
            g = gcd64(n < 0 ? -n : n, d);
            q.r_num = 32'(n / g);
            q.r_den = 31'(d / g);
        end
        return q;
    endfunction

    function automatic quotient_t rational_result(operands_t op);
        quotient_t q;
        longint an, ad, bn, bd;
        an = op.a_num;
        ad = op.a_den;
        bn = op.b_num;
        bd = {33'd0, op.b_den};
        q = '0;
        case (op.cmd)
            CMD_ADD:  q = reduce_frac(an * bd + bn * ad, ad * bd);
            CMD_SUB:  q = reduce_frac(an * bd - bn * ad, ad * bd);
            CMD_MUL:  q = reduce_frac(an * bn, ad * bd);
            CMD_DIV:
                if (bn == 0)
                    q.error = ERR_DIV0;
                else
                    q = reduce_frac(an * bd, ad * bn);
            CMD_CMP:
            begin
                q.less = (an * bd < bn * ad);
                q.equal = (an == bn) && (ad == bd);
            end
            CMD_NORM: q = reduce_frac(an, ad);
            default:  q = '0;
        endcase
        return q;
    endfunction

    function automatic operands_t mk(logic [2:0] c, longint an, longint ad, longint bn,
                                     longint bd);
        operands_t op;
        op.cmd = c;
        op.a_num = 32'(an);
        op.a_den = 32'(ad);
        op.b_num = 32'(bn);
        op.b_den = 31'(bd);
        return op;
    endfunction

    function automatic int small_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] big_mag();
        logic [31:0] v;
        v = $urandom | 32'h4000_0000;
        v[31] = 1'b0;
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // operand values stay small where the unit runs its gcd loop, but for normalise cases with a large common factor
    function automatic operands_t random_ops();
        operands_t op;
        logic [159:0] rnd;
        int sel, span, k, m, g;
        sel = $urandom_range(0, 99);
        span = ($urandom_range(0, 19) == 0) ? 90 : 25;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        op = rnd[129:0];
        if (sel < 45)
            op = mk(3'($urandom_range(0, 3)), small_val(span), $urandom_range(1, span),
                    small_val(span), $urandom_range(1, span));
        else if (sel < 55)
        begin
            k = small_val(15);
            m = small_val(15);
            g = $urandom_range(1, 134217727);
            op.cmd = CMD_NORM;
            op.a_num = 32'(k * g);
            op.a_den = 32'(m * g);
        end
        else if (sel < 70)
        begin
            op.cmd = CMD_CMP;
            if ($urandom_range(0, 3) == 0)
            begin
                op.b_num = op.a_num;
                op.b_den = op.a_den[30:0];
            end
        end
        else if (sel < 80)
            op = mk(CMD_MUL, big_mag(), big_mag(), big_mag(), big_mag() & 32'h7FFF_FFFF);
        else if (sel < 85)
            op.cmd = $urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7;
        else if (sel < 90)
        begin
            op.cmd = CMD_DIV;
            op.b_num = '0;
        end
        else
            op = mk(3'($urandom_range(0, 5)), small_val(9) * $urandom_range(0, 1),
                    small_val(9), small_val(9), $urandom_range(0, 9));
        return op;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        stim_done = 1'b0;
        pending_ops.push_back(mk(CMD_ADD, 1, 2, 1, 3));
        pending_ops.push_back(mk(CMD_SUB, 1, 2, 1, 2));
        pending_ops.push_back(mk(CMD_MUL, -3, 4, 2, 9));
        pending_ops.push_back(mk(CMD_DIV, 5, 6, -5, 3));
        pending_ops.push_back(mk(CMD_DIV, 5, 6, 0, 3));
        pending_ops.push_back(mk(CMD_CMP, 1, 3, 1, 2));
        pending_ops.push_back(mk(CMD_CMP, 7, 9, 7, 9));
        pending_ops.push_back(mk(CMD_CMP, WMIN, 1, WMAX, 1));
        pending_ops.push_back(mk(CMD_CMP, WMAX, WMIN, WMIN, WMAX));
        pending_ops.push_back(mk(CMD_NORM, 6, -4, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, 0, 5, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, 0, -5, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, 3, 0, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, WMIN, -1, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, 5, WMIN, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, WMIN, WMIN, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, WMAX, WMAX, 0, 1));
        pending_ops.push_back(mk(CMD_NORM, 2147483646, -1073741823, 0, 1));
        pending_ops.push_back(mk(CMD_MUL, WMIN, 1, WMIN, 1));
        pending_ops.push_back(mk(CMD_ADD, WMAX, 1, 1, 2));
        pending_ops.push_back(mk(CMD_ADD, 1, 0, 1, 2));
        pending_ops.push_back(mk(CMD_MUL, 1, 2, 1, 0));
        pending_ops.push_back(mk(CMD_ADD, 2, -3, 1, 3));
        pending_ops.push_back(mk(CMD_NOP6, WMIN, WMAX, -1, WMAX));
        pending_ops.push_back(mk(CMD_NOP7, -1, -1, -1, WMAX));
        repeat (N_RANDOM) pending_ops.push_back(random_ops());
        total_items = pending_ops.size();
        stim_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left <= 0;
            accepted <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(rational_result(in_flight));
                accepted <= accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    in_flight = pending_ops.pop_front();
                    s_tdata <= {6'd0, in_flight.b_den, in_flight.b_num, in_flight.a_den,
                                in_flight.a_num, in_flight.cmd};
                    s_tvalid <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver stall so the unit backs up against the sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted == 120)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        quotient_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[66:0];
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing pending: %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.r_num !== want.r_num || got.r_den !== want.r_den ||
                        got.less !== want.less || got.equal !== want.equal ||
                        got.error !== want.error)
                    begin
                        $display("%0t: exp num=%0d den=%0d lt=%b eq=%b err=%0d", $time,
                                 want.r_num, want.r_den, want.less, want.equal, want.error);
                        $display("%0t: got num=%0d den=%0d lt=%b eq=%b err=%0d", $time,
                                 got.r_num, got.r_den, got.less, got.equal, got.error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (hold_left > 1 || (!hold_done && accepted == 120))
                m_tready <= 1'b0;
            else if ($urandom_range(0, 9) < 3)
                m_tready <= (pick_gap() == 0);
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done && results_seen == total_items);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0 && accepted == total_items)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
